>>> design/rtdp_pkg.sv
`default_nettype none

package rtdp_pkg;

    // Default sizes
    localparam int NUM_WIDTH_DEF = 16;
    localparam int RANGE_MAX_DEF = 64;

    // First trial divisor
    localparam int FIRST_DIV = 2;

    // Range sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_top_state;

    // Candidate tester states
    typedef enum logic [1:0] {
        T_IDLE,
        T_CHECK,
        T_DIV
    } t_test_state;

    // Tester verdict toward the range sequencer
    typedef struct packed {
        logic done;
        logic prime;
    } t_test_res;

endpackage

`default_nettype wire

>>> design/range_trial_division_prime_test.sv
`default_nettype none

// Per candidate, each trial divisor from 2 up to floor(sqrt(n)) is a bit-serial remainder
// pass plus control; an exact divisor ends the test early, and 0 and 1 are reported not
// prime without a pass. Each result strobes in the cycle after the tester reports its
// candidate done. One range item at a time; busy falls as its last result is strobed.
// Results appear on o_valid for one cycle and are never held: the receiver cannot stall.
// Synchronous active-low reset returns to idle.
module range_trial_division_prime_test_top #(
    parameter int NUM_WIDTH = rtdp_pkg::NUM_WIDTH_DEF,
    parameter int RANGE_MAX = rtdp_pkg::RANGE_MAX_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [NUM_WIDTH-1:0] i_range_start,
    input  wire logic [NUM_WIDTH-1:0] i_range_end,
    output logic                      o_valid,
    output logic [NUM_WIDTH-1:0]      o_candidate,
    output logic                      o_is_prime,
    output logic                      o_last_of_range,
    output logic                      o_truncated
);

    localparam int CW = $clog2(RANGE_MAX + 1);

    rtdp_pkg::t_top_state r_state, n_state;
    logic [NUM_WIDTH-1:0] r_cur, n_cur;
    logic [CW-1:0]        r_left, n_left;
    logic                 r_cut, n_cut;
    logic                 r_valid, n_valid;
    logic [NUM_WIDTH-1:0] r_cand, n_cand;
    logic                 r_prime, n_prime;
    logic                 r_last, n_last;
    logic                 r_trunc, n_trunc;
    logic [NUM_WIDTH-1:0] span;
    logic                 too_long;
    logic                 test_start;
    rtdp_pkg::t_test_res  test_res;

    rtdp_test #(.NUM_WIDTH(NUM_WIDTH)) u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (test_start),
        .i_num   (r_cur),
        .o_res   (test_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtdp_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_cur   <= n_cur;
        r_left  <= n_left;
        r_cut   <= n_cut;
        r_cand  <= n_cand;
        r_prime <= n_prime;
        r_last  <= n_last;
        r_trunc <= n_trunc;
    end

    // Walk the range, one candidate through the tester at a time
    always_comb begin
        span       = i_range_end - i_range_start;
        too_long   = (32'(span) >= 32'(RANGE_MAX));
        n_state    = r_state;
        n_cur      = r_cur;
        n_left     = r_left;
        n_cut      = r_cut;
        n_valid    = 1'b0;
        n_cand     = r_cand;
        n_prime    = r_prime;
        n_last     = r_last;
        n_trunc    = r_trunc;
        test_start = 1'b0;
        unique case (r_state)
            rtdp_pkg::S_IDLE: begin
                // drop empty ranges
                if (start && (i_range_end >= i_range_start)) begin
                    n_cur   = i_range_start;
                    n_cut   = too_long;
                    n_left  = too_long ? CW'(RANGE_MAX - 1) : CW'(span);
                    n_state = rtdp_pkg::S_RUN;
                end
            end
            rtdp_pkg::S_RUN: begin
                test_start = 1'b1;
                n_state    = rtdp_pkg::S_WAIT;
            end
            rtdp_pkg::S_WAIT: begin
                if (test_res.done) begin
                    n_valid = 1'b1;
                    n_cand  = r_cur;
                    n_prime = test_res.prime;
                    n_last  = (r_left == '0);
                    n_trunc = r_cut;
                    if (r_left == '0) begin
                        n_state = rtdp_pkg::S_IDLE;
                    end else begin
                        n_left  = r_left - CW'(1);
                        n_cur   = r_cur + NUM_WIDTH'(1);
                        n_state = rtdp_pkg::S_RUN;
                    end
                end
            end
            default: n_state = rtdp_pkg::S_IDLE;
        endcase
    end

    assign busy            = (r_state != rtdp_pkg::S_IDLE);
    assign o_valid         = r_valid;
    assign o_candidate     = r_cand;
    assign o_is_prime      = r_prime;
    assign o_last_of_range = r_last;
    assign o_truncated     = r_trunc;

endmodule

`default_nettype wire

>>> design/rtdp_rem.sv
`default_nettype none

// Bit-serial restoring remainder: one dividend bit enters per cycle.
module rtdp_rem #(
    parameter int NUM_WIDTH = rtdp_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [NUM_WIDTH-1:0] i_dividend,
    input  wire logic [NUM_WIDTH-1:0] i_divisor,
    output logic                      o_done,
    output logic                      o_zero
);

    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [NUM_WIDTH-1:0] r_q, n_q;
    logic [NUM_WIDTH:0]   r_rem, n_rem;
    logic [NUM_WIDTH-1:0] r_div, n_div;
    logic [NUM_WIDTH:0]   shifted;
    logic [NUM_WIDTH:0]   div_ext;

    // Shift in next dividend bit, subtract divisor when it fits
    always_comb begin
        shifted = {r_rem[NUM_WIDTH-1:0], r_q[NUM_WIDTH-1]};
        div_ext = {1'b0, r_div};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NUM_WIDTH);
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = (shifted >= div_ext) ? shifted - div_ext : shifted;
            n_q   = {r_q[NUM_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold control under reset, payload free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_zero = (r_rem == '0);

endmodule

`default_nettype wire

>>> design/rtdp_test.sv
`default_nettype none

// Trial division of one candidate: divisors from two while d*d <= n.
module rtdp_test #(
    parameter int NUM_WIDTH = rtdp_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [NUM_WIDTH-1:0] i_num,
    output rtdp_pkg::t_test_res       o_res
);

    localparam int SW = NUM_WIDTH + 2;

    rtdp_pkg::t_test_state r_state, n_state;
    logic                 r_done, n_done;
    logic                 r_prime, n_prime;
    logic [NUM_WIDTH-1:0] r_num, n_num;
    logic [NUM_WIDTH-1:0] r_d, n_d;
    logic [SW-1:0]        r_sq, n_sq;
    logic                 rem_start;
    logic                 rem_done;
    logic                 rem_zero;

    rtdp_rem #(.NUM_WIDTH(NUM_WIDTH)) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_num),
        .i_divisor  (r_d),
        .o_done     (rem_done),
        .o_zero     (rem_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtdp_pkg::T_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_prime <= n_prime;
        r_num   <= n_num;
        r_d     <= n_d;
        r_sq    <= n_sq;
    end

    // Step divisor and its square; stop at first zero remainder
    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_prime   = r_prime;
        n_num     = r_num;
        n_d       = r_d;
        n_sq      = r_sq;
        rem_start = 1'b0;
        unique case (r_state)
            rtdp_pkg::T_IDLE: begin
                if (i_start) begin
                    n_num = i_num;
                    n_d   = NUM_WIDTH'(rtdp_pkg::FIRST_DIV);
                    n_sq  = SW'(rtdp_pkg::FIRST_DIV * rtdp_pkg::FIRST_DIV);
                    if (i_num < NUM_WIDTH'(rtdp_pkg::FIRST_DIV)) begin
                        n_prime = 1'b0;
                        n_done  = 1'b1;
                    end else begin
                        n_state = rtdp_pkg::T_CHECK;
                    end
                end
            end
            rtdp_pkg::T_CHECK: begin
                if (r_sq > {2'b00, r_num}) begin
                    n_prime = 1'b1;
                    n_done  = 1'b1;
                    n_state = rtdp_pkg::T_IDLE;
                end else begin
                    rem_start = 1'b1;
                    n_state   = rtdp_pkg::T_DIV;
                end
            end
            rtdp_pkg::T_DIV: begin
                if (rem_done) begin
                    if (rem_zero) begin
                        n_prime = 1'b0;
                        n_done  = 1'b1;
                        n_state = rtdp_pkg::T_IDLE;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_sq    = r_sq + {1'b0, r_d, 1'b1};
                        n_d     = r_d + NUM_WIDTH'(1);
                        n_state = rtdp_pkg::T_CHECK;
                    end
                end
            end
            default: n_state = rtdp_pkg::T_IDLE;
        endcase
    end

    assign o_res.done  = r_done;
    assign o_res.prime = r_prime;

endmodule

`default_nettype wire
